/* src/fsr_pkg.sv */
// Shared constants, types and byte classifiers for the FS prefix rewriter.
package fsr_pkg;

  localparam int unsigned MAX_PREFIXES_DEF = 14;

  localparam logic [7:0] BYTE_FS     = 8'h64;
  localparam logic [7:0] BYTE_GS     = 8'h65;
  localparam logic [7:0] BYTE_OPSIZE = 8'h66;
  localparam logic [7:0] BYTE_ADSIZE = 8'h67;
  localparam logic [7:0] BYTE_REPNE  = 8'hf2;
  localparam logic [7:0] BYTE_REP    = 8'hf3;
  localparam logic [7:0] BYTE_REX_LO = 8'h40;
  localparam logic [7:0] BYTE_REX_HI = 8'h4f;
  localparam logic [7:0] BYTE_ESC    = 8'h0f;

  typedef struct packed {
    logic        valid;
    logic        released;
    logic        start;
    logic        tail;
    logic        run_last;
    logic        seg_last;
    logic        rew;
    logic [7:0]  data;
    logic [31:0] total;
  } cell_t;

  typedef struct packed {
    logic        push_en;
    cell_t       push;
    logic        release_en;
    logic        match;
    logic        tail_last;
    logic [31:0] total;
  } bcast_t;

  function automatic logic is_legacy(input logic [7:0] b);
    return (b == BYTE_OPSIZE) || (b == BYTE_ADSIZE) || (b == BYTE_REPNE) || (b == BYTE_REP);
  endfunction

  function automatic logic is_rex(input logic [7:0] b);
    return (b >= BYTE_REX_LO) && (b <= BYTE_REX_HI);
  endfunction

  function automatic logic is_primary(input logic [7:0] b);
    logic hit;
    unique case (b)
      8'h01, 8'h03, 8'h29, 8'h2b, 8'h31, 8'h33, 8'h39, 8'h3b,
      8'h80, 8'h81, 8'h83, 8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8d,
      8'hc6, 8'hc7, 8'hf7, 8'hff: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_secondary(input logic [7:0] b);
    logic hit;
    unique case (b)
      8'haf, 8'hb1, 8'hb6, 8'hb7, 8'hbe, 8'hbf, 8'hc1: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

/* src/fsr_cell.sv */
// One cell of the byte chain: holds one byte and shifts toward the head on a pop.
module fsr_cell #(
  parameter int unsigned DEPTH = fsr_pkg::MAX_PREFIXES_DEF + 4,
  parameter int unsigned IDX   = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop,
  input  fsr_pkg::cell_t           nbr,
  input  fsr_pkg::bcast_t          bc,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  output fsr_pkg::cell_t           q
);
  import fsr_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  cell_t src;
  cell_t cell_nxt;
  cell_t cell_r;

  always_comb begin
    src = pop ? nbr : cell_r;
    cell_nxt = src;
    if (src.valid && !src.released && bc.release_en) begin
      cell_nxt.released = 1'b1;
      cell_nxt.total    = bc.total;
      cell_nxt.run_last = bc.tail_last & src.tail;
      cell_nxt.seg_last = 1'b0;
      if (bc.match && src.start) begin
        cell_nxt.data = BYTE_GS;
        cell_nxt.rew  = 1'b1;
      end
    end
    if (src.valid && !src.released && bc.push_en) begin
      cell_nxt.tail = 1'b0;
    end
    if (bc.push_en && (wr_idx == MY_IDX)) begin
      cell_nxt = bc.push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign q = cell_r;

endmodule

/* src/fsr_ctrl.sv */
// Scan controller: classifies each accepted byte and drives the chain broadcast.
module fsr_ctrl #(
  parameter int unsigned MAX_PREFIXES = fsr_pkg::MAX_PREFIXES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      byte_in,
  input  logic            segment_end,
  output fsr_pkg::bcast_t bc
);
  import fsr_pkg::*;

  localparam int unsigned HW = $clog2(MAX_PREFIXES + 4);
  localparam logic [HW-1:0] MAX_HELD = HW'(MAX_PREFIXES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PFX,
    ST_REX,
    ST_ESC
  } state_t;

  state_t        state_r, state_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [31:0]   count_r;

  logic pending, match, fail, hold, new_start, new_pending, ends;

  always_comb begin
    match     = 1'b0;
    fail      = 1'b0;
    hold      = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_ESC: begin
        match = is_secondary(byte_in);
        fail  = !match;
      end
      ST_PFX: begin
        priority if (is_legacy(byte_in)) begin
          hold = (held_r <= MAX_HELD);
          fail = !hold;
        end else if (is_rex(byte_in)) begin
          hold      = 1'b1;
          state_nxt = ST_REX;
        end else if (is_primary(byte_in)) begin
          match = 1'b1;
        end else if (byte_in == BYTE_ESC) begin
          hold      = 1'b1;
          state_nxt = ST_ESC;
        end else begin
          fail = 1'b1;
        end
      end
      ST_REX: begin
        priority if (is_primary(byte_in)) begin
          match = 1'b1;
        end else if (byte_in == BYTE_ESC) begin
          hold      = 1'b1;
          state_nxt = ST_ESC;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
      end
    endcase

    pending     = (state_r != ST_IDLE);
    ends        = match | fail;
    new_start   = (byte_in == BYTE_FS) && (!pending || fail);
    new_pending = !segment_end && (new_start || (pending && !ends));

    held_nxt = held_r;
    if (segment_end) begin
      state_nxt = ST_IDLE;
      held_nxt  = '0;
    end else if (new_start) begin
      state_nxt = ST_PFX;
      held_nxt  = HW'(1);
    end else if (ends) begin
      state_nxt = ST_IDLE;
      held_nxt  = '0;
    end else if (hold) begin
      held_nxt = held_r + HW'(1);
    end

    bc.push_en        = accept;
    bc.push.valid     = 1'b1;
    bc.push.released  = !new_pending;
    bc.push.start     = new_start;
    bc.push.tail      = 1'b1;
    bc.push.run_last  = !new_pending;
    bc.push.seg_last  = !new_pending && segment_end;
    bc.push.rew       = 1'b0;
    bc.push.data      = byte_in;
    bc.push.total     = count_r + {31'd0, match};
    bc.release_en     = accept && pending && (ends || segment_end);
    bc.match          = match;
    bc.tail_last      = new_pending;
    bc.total          = count_r + {31'd0, match};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      count_r <= count_r + {31'd0, match};
    end
  end

endmodule

/* src/fs_prefix_tls_rewriter.sv */
// Top level of the FS-to-GS prefix rewriter: scan controller and byte chain.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | byte_in, segment_end
//  out_    | output    | out_valid/out_ready| byte_out, was_rewritten, run_last,
//          |           |                    | segment_last, rewrite_total
//
// Each accepted byte is written into the chain in the cycle of its transfer and
// reaches the output register at the head in the next cycle at the earliest.
// The head cell is the output register; one result leaves per cycle while out_ready
// is high, and input is taken while the chain has room.
// A held run stays in the chain until its deciding byte arrives.
// Reset is synchronous and empties the chain and clears the rewrite count.
module fs_prefix_tls_rewriter #(
  parameter int unsigned MAX_PREFIXES = fsr_pkg::MAX_PREFIXES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_segment_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic        out_was_rewritten,
  output logic        out_run_last,
  output logic        out_segment_last,
  output logic [31:0] out_rewrite_total
);
  import fsr_pkg::*;

  localparam int unsigned DEPTH = MAX_PREFIXES + 4;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  cell_t   cells [DEPTH];
  cell_t   nbrs  [DEPTH];
  bcast_t  bc;
  logic    accept, pop;
  logic [CW-1:0] fill_r, fill_nxt, after_pop;
  logic [IW-1:0] wr_idx;

  assign in_ready  = (fill_r < DEPTH_C);
  assign accept    = in_valid && in_ready;
  assign out_valid = cells[0].valid && cells[0].released;
  assign pop       = out_valid && out_ready;
  assign after_pop = fill_r - {{(CW-1){1'b0}}, pop};
  assign wr_idx    = after_pop[IW-1:0];
  assign fill_nxt  = after_pop + {{(CW-1){1'b0}}, accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  fsr_ctrl #(.MAX_PREFIXES(MAX_PREFIXES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .byte_in     (in_byte_in),
    .segment_end (in_segment_end),
    .bc          (bc)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_end
      assign nbrs[i] = '0;
    end else begin : g_mid
      assign nbrs[i] = cells[i+1];
    end
    fsr_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .pop    (pop),
      .nbr    (nbrs[i]),
      .bc     (bc),
      .wr_idx (wr_idx),
      .q      (cells[i])
    );
  end

  assign out_byte_out      = cells[0].data;
  assign out_was_rewritten = cells[0].rew;
  assign out_run_last      = cells[0].run_last;
  assign out_segment_last  = cells[0].seg_last;
  assign out_rewrite_total = cells[0].total;

endmodule

/* src/fsr_checker.sv */
// Port-level checker for the rewriter and its bind to the top level.
module fsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte_out,
  input logic        out_was_rewritten,
  input logic        out_run_last,
  input logic        out_segment_last,
  input logic [31:0] out_rewrite_total
);
  import fsr_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_out)
      && $stable(out_rewrite_total))
    else $error("stalled output transfer changed");

  a_rewrite_is_gs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_rewritten |-> out_byte_out == BYTE_GS)
    else $error("rewritten byte is not the GS prefix");

  a_seg_implies_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_segment_last |-> out_run_last)
    else $error("segment end flagged on a result that is not the last of its run");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind fs_prefix_tls_rewriter fsr_checker u_fsr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_byte_out      (out_byte_out),
  .out_was_rewritten (out_was_rewritten),
  .out_run_last      (out_run_last),
  .out_segment_last  (out_segment_last),
  .out_rewrite_total (out_rewrite_total)
);

/* dv/tb_fs_prefix_tls_rewriter.sv */
// Self-checking testbench for the FS prefix rewriter: directed table, random code, scoreboard.
module tb_fs_prefix_tls_rewriter;
  import fsr_pkg::*;

  localparam int PFX_LIMIT = MAX_PREFIXES_DEF;
  localparam int HOLD_MAX = PFX_LIMIT + 3;
  localparam int RAND_ITEMS = 310;
  localparam int QUIET_AFTER = 270;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  localparam int LIST_LEGACY  = 0;
  localparam int LIST_PRIMARY = 1;
  localparam int LIST_ESC     = 2;

  typedef enum logic [1:0] {SCAN_PREFIX, SCAN_AFTER_REX, SCAN_AFTER_ESC} scan_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        rew;
    logic        run_last;
    logic        seg_last;
    logic [31:0] total;
  } code_res_t;

  typedef struct packed {
    logic        pinned;
    logic [7:0]  data;
    logic        rew;
    logic [31:0] total;
  } pin_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        seg;
    logic [4:0]  reps;
    logic        pinned;
    logic [7:0]  xdata;
    logic        xrew;
    logic [31:0] xtotal;
  } row_t;

  localparam logic [7:0] LEGACY_OPS [4] = '{BYTE_OPSIZE, BYTE_ADSIZE, BYTE_REPNE, BYTE_REP};
  localparam logic [7:0] ONE_BYTE_OPS [20] = '{
    8'h01, 8'h03, 8'h29, 8'h2b, 8'h31, 8'h33, 8'h39, 8'h3b, 8'h80, 8'h81,
    8'h83, 8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8d, 8'hc6, 8'hc7, 8'hf7, 8'hff};
  localparam logic [7:0] ESC_OPS [7] = '{8'haf, 8'hb1, 8'hb6, 8'hb7, 8'hbe, 8'hbf, 8'hc1};

  localparam row_t DIR_TAB [27] = '{
    '{8'h00,   1'b0, 5'd1,  1'b1, 8'h00,   1'b0, 32'd0},
    '{8'hff,   1'b0, 5'd1,  1'b1, 8'hff,   1'b0, 32'd0},
    '{BYTE_FS, 1'b1, 5'd1,  1'b1, BYTE_FS, 1'b0, 32'd0},
    '{BYTE_FS, 1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h8b,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{BYTE_FS, 1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h66,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h4f,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h0f,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'haf,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{BYTE_FS, 1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{BYTE_FS, 1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h01,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{BYTE_FS, 1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h0f,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h00,   1'b1, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{BYTE_FS, 1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h66,   1'b0, 5'd15, 1'b0, 8'h00,   1'b0, 32'd0},
    '{BYTE_FS, 1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h40,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h40,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{BYTE_FS, 1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'hf3,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'hf2,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h67,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'h0f,   1'b0, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0},
    '{8'hc1,   1'b1, 5'd1,  1'b0, 8'h00,   1'b0, 32'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'h00;
  logic        in_segment_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte_out;
  logic        out_was_rewritten;
  logic        out_run_last;
  logic        out_segment_last;
  logic [31:0] out_rewrite_total;

  fs_prefix_tls_rewriter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_in        (in_byte_in),
    .in_segment_end    (in_segment_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_out      (out_byte_out),
    .out_was_rewritten (out_was_rewritten),
    .out_run_last      (out_run_last),
    .out_segment_last  (out_segment_last),
    .out_rewrite_total (out_rewrite_total)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic        hold_on = 1'b0;
  scan_t       scan = SCAN_PREFIX;
  int          held_n = 0;
  logic [7:0]  held [HOLD_MAX];
  logic [31:0] rew_count = 32'd0;

  code_res_t step_q [$];
  code_res_t rewritten_q [$];
  pin_t      pin_q [$];
  int        errors = 0;
  int        cycles = 0;
  int        items_sent = 0;
  bit        quiet = 1'b0;

  function automatic bit is_in(input logic [7:0] b, input int which);
    bit hit;
    hit = 1'b0;
    case (which)
      LIST_LEGACY: foreach (LEGACY_OPS[i]) hit |= (LEGACY_OPS[i] == b);
      LIST_PRIMARY: foreach (ONE_BYTE_OPS[i]) hit |= (ONE_BYTE_OPS[i] == b);
      default: foreach (ESC_OPS[i]) hit |= (ESC_OPS[i] == b);
    endcase
    return hit;
  endfunction

  task automatic emit(input logic [7:0] b, input logic rew);
    step_q.push_back('{b, rew, 1'b0, 1'b0, 32'd0});
  endtask

  task automatic release_held(input bit matched);
    for (int i = 0; i < held_n; i++) begin
      if (i == 0 && matched) emit(BYTE_GS, 1'b1);
      else emit(held[i], 1'b0);
    end
    held_n = 0;
    hold_on = 1'b0;
    scan = SCAN_PREFIX;
  endtask

  task automatic begin_hold();
    held[0] = BYTE_FS;
    held_n = 1;
    hold_on = 1'b1;
    scan = SCAN_PREFIX;
  endtask

  task automatic hold(input logic [7:0] b);
    held[held_n] = b;
    held_n++;
  endtask

  task automatic fail_on(input logic [7:0] b);
    release_held(1'b0);
    if (b == BYTE_FS) begin_hold();
    else emit(b, 1'b0);
  endtask

  task automatic match_on(input logic [7:0] b);
    rew_count++;
    release_held(1'b1);
    emit(b, 1'b0);
  endtask

  task automatic rewrite_step(input logic [7:0] b, input logic seg);
    step_q.delete();
    if (!hold_on) begin
      if (b == BYTE_FS) begin_hold();
      else emit(b, 1'b0);
    end else if (scan == SCAN_AFTER_ESC) begin
      if (is_in(b, LIST_ESC)) match_on(b);
      else fail_on(b);
    end else if (scan == SCAN_PREFIX && is_in(b, LIST_LEGACY)) begin
      if (held_n - 1 < PFX_LIMIT) hold(b);
      else fail_on(b);
    end else if (scan == SCAN_PREFIX && b >= BYTE_REX_LO && b <= BYTE_REX_HI) begin
      hold(b);
      scan = SCAN_AFTER_REX;
    end else if (is_in(b, LIST_PRIMARY)) begin
      match_on(b);
    end else if (b == BYTE_ESC) begin
      hold(b);
      scan = SCAN_AFTER_ESC;
    end else begin
      fail_on(b);
    end
    if (seg && hold_on) release_held(1'b0);
    foreach (step_q[i]) step_q[i].total = rew_count;
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].run_last = 1'b1;
      step_q[step_q.size() - 1].seg_last = seg;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pin_t      pin;
    code_res_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pin = pin_q.pop_front();
        rewrite_step(in_byte_in, in_segment_end);
        if (pin.pinned) begin
          rewritten_q.push_back('{pin.data, pin.rew, 1'b1, in_segment_end, pin.total});
        end else begin
          foreach (step_q[i]) rewritten_q.push_back(step_q[i]);
        end
      end
      if (out_valid && out_ready) begin
        if (rewritten_q.size() == 0) begin
          report_mismatch("unexpected byte_out", 32'(out_byte_out), 32'd0);
        end else begin
          want = rewritten_q.pop_front();
          if (out_byte_out !== want.data)
            report_mismatch("byte_out", 32'(out_byte_out), 32'(want.data));
          if (out_was_rewritten !== want.rew)
            report_mismatch("was_rewritten", 32'(out_was_rewritten), 32'(want.rew));
          if (out_run_last !== want.run_last)
            report_mismatch("run_last", 32'(out_run_last), 32'(want.run_last));
          if (out_segment_last !== want.seg_last)
            report_mismatch("segment_last", 32'(out_segment_last), 32'(want.seg_last));
          if (out_rewrite_total !== want.total)
            report_mismatch("rewrite_total", out_rewrite_total, want.total);
        end
      end
    end
  end

  always @(posedge clk) begin
    int stall_left;
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_code(input logic [7:0] b, input logic seg, input pin_t pin);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin_q.push_back(pin);
    in_valid <= 1'b1;
    in_byte_in <= b;
    in_segment_end <= seg;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_rand(input logic [7:0] b);
    send_code(b, ($urandom_range(0, 29) == 0), '0);
  endtask

  // One instruction-shaped sequence behind an FS prefix, sometimes broken.
  task automatic send_insn();
    int npfx;
    int kind;
    npfx = ($urandom_range(0, 11) == 0) ? $urandom_range(12, PFX_LIMIT + 2)
                                        : $urandom_range(0, 3);
    send_rand(BYTE_FS);
    repeat (npfx) send_rand(LEGACY_OPS[$urandom_range(0, 3)]);
    if ($urandom_range(0, 1)) send_rand(BYTE_REX_LO + 8'($urandom_range(0, 15)));
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      send_rand(ONE_BYTE_OPS[$urandom_range(0, 19)]);
    end else if (kind < 7) begin
      send_rand(BYTE_ESC);
      if ($urandom_range(0, 3) == 0) send_rand(8'($urandom));
      else send_rand(ESC_OPS[$urandom_range(0, 6)]);
    end else if (kind == 7) begin
      send_rand(BYTE_FS);
    end else begin
      send_rand(8'($urandom));
    end
  endtask

  initial begin
    pin_t pin;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIR_TAB[r]) begin
      pin = '{DIR_TAB[r].pinned, DIR_TAB[r].xdata, DIR_TAB[r].xrew, DIR_TAB[r].xtotal};
      repeat (DIR_TAB[r].reps) send_code(DIR_TAB[r].data, DIR_TAB[r].seg, pin);
    end
    while (items_sent < RAND_ITEMS) begin
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        send_insn();
      end else begin
        repeat ($urandom_range(1, 6)) send_code(8'($urandom), ($urandom_range(0, 7) == 0), '0);
      end
    end
    quiet = 1'b1;
    in_valid <= 1'b0;
    @(posedge clk);
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rewritten_q.size() != 0)
      report_mismatch("results left over", 32'(rewritten_q.size()), 32'd0);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
